// ===== hdl/ec2d_pkg.sv =====
// Shared types and constants for the 2-D elastic collision core.
// Used by the core, its port checker and the testbench; depends on nothing else.
package ec2d_pkg;

    // Width of every Q-format value on the ports.
    localparam int Q_W      = 32;
    // Fraction bits of the mass ratio k.
    localparam int KBITS    = 28;
    // Quotient bits of the mass-ratio divider and width of signed k.
    localparam int KQ_W     = KBITS + 1;
    localparam int K_W      = KBITS + 2;
    // Widths around the magnitude normalization.
    localparam int AW       = Q_W + 1;
    localparam int NORM_MSB = Q_W - 2;
    localparam int SH_W     = $clog2(Q_W - 1);
    // Square root: 64-bit radicand, one root bit per stage.
    localparam int SUMSQ_W  = 2 * Q_W;
    localparam int SQ_N     = Q_W;
    localparam int SQ_REM_W = Q_W + 3;
    // Rotated, difference and post-collision velocity widths.
    localparam int RW       = Q_W + 2;
    localparam int DW       = Q_W + 3;
    localparam int NW       = Q_W + 5;

    typedef logic signed [Q_W-1:0] t_q;

endpackage

// ===== hdl/elastic_collision_2d_core.sv =====
// Pipelined 2-D elastic collision of two particles in signed fixed point.
// Depends on ec2d_pkg for widths and the port value type.
//
//  Channel | Signals                               | Handshake
//  --------+---------------------------------------+------------------------
//  in      | i_pos_*, i_vel_*, i_mass_a, i_mass_b  | i_valid / o_stall
//  out     | o_new_vel_*, o_saturated              | o_valid / i_stall
//
// One item is accepted per cycle while o_stall is low.
// Most of the stages are the square root (one root bit per stage) followed by
// the cosine/sine divider (one quotient bit per stage).
// Reset is synchronous and clears only the valid bits and the skid flag.
// When the output is stalled the next result goes into a skid register; only
// when that is full does the whole pipeline hold and o_stall rise.
module elastic_collision_2d_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  ec2d_pkg::t_q     i_pos_a_x,
    input  ec2d_pkg::t_q     i_pos_a_y,
    input  ec2d_pkg::t_q     i_pos_b_x,
    input  ec2d_pkg::t_q     i_pos_b_y,
    input  ec2d_pkg::t_q     i_vel_a_x,
    input  ec2d_pkg::t_q     i_vel_a_y,
    input  ec2d_pkg::t_q     i_vel_b_x,
    input  ec2d_pkg::t_q     i_vel_b_y,
    input  logic [ec2d_pkg::Q_W-1:0] i_mass_a,
    input  logic [ec2d_pkg::Q_W-1:0] i_mass_b,
    output logic             o_valid,
    input  logic             i_stall,
    output ec2d_pkg::t_q     o_new_vel_a_x,
    output ec2d_pkg::t_q     o_new_vel_a_y,
    output ec2d_pkg::t_q     o_new_vel_b_x,
    output ec2d_pkg::t_q     o_new_vel_b_y,
    output logic             o_saturated
);
    import ec2d_pkg::*;

    localparam int CW  = FRAC_BITS + 2;
    localparam int QD  = FRAC_BITS + 1;
    localparam int PW1 = CW + Q_W;
    localparam int PW2 = CW + NW;
    localparam int KPW = K_W + DW;
    localparam int SW2 = PW2 + 1;

    typedef struct packed {
        logic                 dxz;
        logic                 sneg;
        logic [AW-1:0]        kabs;
        logic                 kneg;
        logic [AW-1:0]        msum;
        logic [3:0][Q_W-1:0]  vel;
    } t_side;

    typedef struct packed {
        logic                 valid;
        logic signed [AW-1:0] dx;
        logic signed [AW-1:0] dy;
        logic signed [AW-1:0] kd;
        logic [AW-1:0]        msum;
        logic [3:0][Q_W-1:0]  vel;
    } t_s0;

    typedef struct packed {
        logic                 valid;
        t_side                side;
        logic [AW-1:0]        ax;
        logic [AW-1:0]        ay;
    } t_s1;

    typedef struct packed {
        logic                 valid;
        t_side                side;
        logic [AW-1:0]        ax;
        logic [AW-1:0]        ay;
        logic                 big;
        logic [SH_W-1:0]      sh;
    } t_s2;

    typedef struct packed {
        logic                 valid;
        t_side                side;
        logic [Q_W-1:0]       axn;
        logic [Q_W-1:0]       ayn;
    } t_s3;

    typedef struct packed {
        logic                 valid;
        t_side                side;
        logic [Q_W-1:0]       axn;
        logic [Q_W-1:0]       ayn;
        logic [SUMSQ_W-1:0]   xsq;
        logic [SUMSQ_W-1:0]   ysq;
    } t_s4;

    typedef struct packed {
        logic                 valid;
        t_side                side;
        logic [Q_W-1:0]       axn;
        logic [Q_W-1:0]       ayn;
        logic [SUMSQ_W-1:0]   rad;
        logic [SQ_N-1:0]      root;
        logic [SQ_REM_W-1:0]  rem;
        logic [KQ_W-1:0]      kq;
        logic [AW-1:0]        krem;
    } t_sq;

    typedef struct packed {
        logic                 valid;
        logic                 dxz;
        logic                 sneg;
        logic signed [K_W-1:0] k;
        logic [Q_W-1:0]       rr;
        logic [Q_W-1:0]       crem;
        logic [Q_W-1:0]       srem;
        logic [QD-1:0]        cq;
        logic [QD-1:0]        sq;
        logic [3:0][Q_W-1:0]  vel;
    } t_dv;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [K_W-1:0] k;
        logic [3:0][Q_W-1:0]  vel;
    } t_cs;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [K_W-1:0] k;
        logic [7:0][PW1-1:0]  p;
    } t_p1;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [K_W-1:0] k;
        logic [3:0][RW-1:0]   r;
    } t_p2;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [K_W-1:0] k;
        logic [3:0][RW-1:0]   r;
        logic signed [DW-1:0] dr;
    } t_p3;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic [3:0][RW-1:0]   r;
        logic signed [KPW-1:0] kp;
    } t_p4;

    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] c;
        logic signed [CW-1:0] s;
        logic signed [NW-1:0] n1x;
        logic signed [NW-1:0] n2x;
        logic signed [RW-1:0] r1y;
        logic signed [RW-1:0] r2y;
    } t_p5;

    typedef struct packed {
        logic                 valid;
        logic [7:0][PW2-1:0]  p;
    } t_p6;

    typedef struct packed {
        logic                 valid;
        logic [3:0][Q_W-1:0]  v;
        logic                 sat;
    } t_res;

    function automatic logic signed [PW1-1:0] mul_cv(
        input logic signed [CW-1:0]  a,
        input logic signed [Q_W-1:0] b
    );
        logic signed [PW1-1:0] ae;
        logic signed [PW1-1:0] be;
        ae = {{(PW1-CW){a[CW-1]}}, a};
        be = {{(PW1-Q_W){b[Q_W-1]}}, b};
        return ae * be;
    endfunction

    function automatic logic signed [PW2-1:0] mul_cn(
        input logic signed [CW-1:0] a,
        input logic signed [NW-1:0] b
    );
        logic signed [PW2-1:0] ae;
        logic signed [PW2-1:0] be;
        ae = {{(PW2-CW){a[CW-1]}}, a};
        be = {{(PW2-NW){b[NW-1]}}, b};
        return ae * be;
    endfunction

    logic en;
    logic accept;

    t_s0  r_s0, n_s0;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_sq  r_sq [0:SQ_N];
    t_sq  n_sq [0:SQ_N];
    t_dv  r_dv [0:QD];
    t_dv  n_dv [0:QD];
    t_cs  r_cs, n_cs;
    t_p1  r_p1, n_p1;
    t_p2  r_p2, n_p2;
    t_p3  r_p3, n_p3;
    t_p4  r_p4, n_p4;
    t_p5  r_p5, n_p5;
    t_p6  r_p6, n_p6;
    t_res r_p7, n_p7;

    t_res r_out;
    t_res r_skid;
    logic r_skid_full;
    logic out_ready;

    // The pipeline moves whenever the skid register is free.
    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;
    assign accept  = i_valid && en;

    // Stage 0: coordinate differences, mass difference and mass sum.
    always_comb begin
        n_s0.valid  = accept;
        n_s0.dx     = {i_pos_a_x[Q_W-1], i_pos_a_x} - {i_pos_b_x[Q_W-1], i_pos_b_x};
        n_s0.dy     = {i_pos_a_y[Q_W-1], i_pos_a_y} - {i_pos_b_y[Q_W-1], i_pos_b_y};
        n_s0.kd     = {1'b0, i_mass_a} - {1'b0, i_mass_b};
        n_s0.msum   = {1'b0, i_mass_a} + {1'b0, i_mass_b};
        n_s0.vel[0] = i_vel_a_x;
        n_s0.vel[1] = i_vel_a_y;
        n_s0.vel[2] = i_vel_b_x;
        n_s0.vel[3] = i_vel_b_y;
    end

    // Stage 1: magnitudes, the equal-x case and the sign of the sine.
    always_comb begin
        n_s1.valid     = r_s0.valid;
        n_s1.ax        = r_s0.dx[AW-1] ? AW'(-r_s0.dx) : AW'(r_s0.dx);
        n_s1.ay        = r_s0.dy[AW-1] ? AW'(-r_s0.dy) : AW'(r_s0.dy);
        n_s1.side.dxz  = (r_s0.dx == '0);
        n_s1.side.sneg = (r_s0.dy != '0) && (r_s0.dx[AW-1] != r_s0.dy[AW-1]);
        n_s1.side.kneg = r_s0.kd[AW-1];
        n_s1.side.kabs = r_s0.kd[AW-1] ? AW'(-r_s0.kd) : AW'(r_s0.kd);
        n_s1.side.msum = r_s0.msum;
        n_s1.side.vel  = r_s0.vel;
    end

    // Stage 2: find the normalizing shift from the larger magnitude.
    always_comb begin
        logic [AW-1:0]   mx;
        logic [SH_W-1:0] pos;
        mx  = (r_s1.ax > r_s1.ay) ? r_s1.ax : r_s1.ay;
        pos = '0;
        for (int i = 0; i <= NORM_MSB; i++) begin
            if (mx[i]) begin
                pos = SH_W'(i);
            end
        end
        n_s2.valid = r_s1.valid;
        n_s2.side  = r_s1.side;
        n_s2.ax    = r_s1.ax;
        n_s2.ay    = r_s1.ay;
        n_s2.big   = mx[AW-1] || mx[AW-2];
        n_s2.sh    = SH_W'(NORM_MSB) - pos;
    end

    // Stage 3: apply the common scale to both magnitudes.
    always_comb begin
        n_s3.valid = r_s2.valid;
        n_s3.side  = r_s2.side;
        n_s3.axn   = r_s2.big ? r_s2.ax[AW-1:1] : (r_s2.ax[Q_W-1:0] << r_s2.sh);
        n_s3.ayn   = r_s2.big ? r_s2.ay[AW-1:1] : (r_s2.ay[Q_W-1:0] << r_s2.sh);
    end

    // Stage 4: squares of the scaled magnitudes.
    always_comb begin
        n_s4.valid = r_s3.valid;
        n_s4.side  = r_s3.side;
        n_s4.axn   = r_s3.axn;
        n_s4.ayn   = r_s3.ayn;
        n_s4.xsq   = SUMSQ_W'(r_s3.axn) * SUMSQ_W'(r_s3.axn);
        n_s4.ysq   = SUMSQ_W'(r_s3.ayn) * SUMSQ_W'(r_s3.ayn);
    end

    // Entry of the root pipeline: sum of squares, cleared root and remainders.
    always_comb begin
        n_sq[0].valid = r_s4.valid;
        n_sq[0].side  = r_s4.side;
        n_sq[0].axn   = r_s4.axn;
        n_sq[0].ayn   = r_s4.ayn;
        n_sq[0].rad   = r_s4.xsq + r_s4.ysq;
        n_sq[0].root  = '0;
        n_sq[0].rem   = '0;
        n_sq[0].kq    = '0;
        n_sq[0].krem  = '0;
    end

    // Root stages: one root bit each; the mass-ratio divider shares these
    // stages and retires one quotient bit in each of the first ones.
    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        always_comb begin
            logic [SQ_REM_W-1:0] num;
            logic [SQ_REM_W-1:0] sub;
            logic                ge;
            logic [AW:0]         knum;
            logic                kge;
            num = {r_sq[j].rem[SQ_REM_W-3:0], r_sq[j].rad[SUMSQ_W-1-2*j -: 2]};
            sub = {{(SQ_REM_W-SQ_N-2){1'b0}}, r_sq[j].root, 2'b01};
            ge  = (num >= sub);
            n_sq[j+1]      = r_sq[j];
            n_sq[j+1].root = {r_sq[j].root[SQ_N-2:0], ge};
            n_sq[j+1].rem  = ge ? (num - sub) : num;
            if (j == 0) begin
                knum = {1'b0, r_sq[j].side.kabs};
            end else begin
                knum = {r_sq[j].krem, 1'b0};
            end
            kge = (knum >= {1'b0, r_sq[j].side.msum});
            if (j < KQ_W) begin
                n_sq[j+1].kq   = {r_sq[j].kq[KQ_W-2:0], kge};
                n_sq[j+1].krem = kge ? AW'(knum - {1'b0, r_sq[j].side.msum})
                                     : AW'(knum);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[j+1].valid <= 1'b0;
            end else if (en) begin
                r_sq[j+1] <= n_sq[j+1];
            end
        end
    end

    // Entry of the divider: signed k, and the scaled magnitudes as numerators.
    always_comb begin
        logic [K_W-1:0] kx;
        kx = {1'b0, r_sq[SQ_N].kq};
        n_dv[0].valid = r_sq[SQ_N].valid;
        n_dv[0].dxz   = r_sq[SQ_N].side.dxz;
        n_dv[0].sneg  = r_sq[SQ_N].side.sneg;
        if (r_sq[SQ_N].side.msum == '0) begin
            n_dv[0].k = '0;
        end else if (r_sq[SQ_N].side.kneg) begin
            n_dv[0].k = -kx;
        end else begin
            n_dv[0].k = kx;
        end
        n_dv[0].rr    = r_sq[SQ_N].root;
        n_dv[0].crem  = r_sq[SQ_N].axn;
        n_dv[0].srem  = r_sq[SQ_N].ayn;
        n_dv[0].cq    = '0;
        n_dv[0].sq    = '0;
        n_dv[0].vel   = r_sq[SQ_N].side.vel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].valid <= 1'b0;
        end else if (en) begin
            r_dv[0] <= n_dv[0];
        end
    end

    // Divider stages: one bit of cosine and of sine magnitude each.
    for (genvar j = 0; j < QD; j++) begin : g_div
        always_comb begin
            logic [Q_W:0] cnum;
            logic [Q_W:0] snum;
            logic         cge;
            logic         sge;
            if (j == 0) begin
                cnum = {1'b0, r_dv[j].crem};
                snum = {1'b0, r_dv[j].srem};
            end else begin
                cnum = {r_dv[j].crem, 1'b0};
                snum = {r_dv[j].srem, 1'b0};
            end
            cge = (cnum >= {1'b0, r_dv[j].rr});
            sge = (snum >= {1'b0, r_dv[j].rr});
            n_dv[j+1]      = r_dv[j];
            n_dv[j+1].cq   = {r_dv[j].cq[QD-2:0], cge};
            n_dv[j+1].sq   = {r_dv[j].sq[QD-2:0], sge};
            n_dv[j+1].crem = cge ? Q_W'(cnum - {1'b0, r_dv[j].rr}) : Q_W'(cnum);
            n_dv[j+1].srem = sge ? Q_W'(snum - {1'b0, r_dv[j].rr}) : Q_W'(snum);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1].valid <= 1'b0;
            end else if (en) begin
                r_dv[j+1] <= n_dv[j+1];
            end
        end
    end

    // Cosine and signed sine; equal x positions give the vertical axis.
    always_comb begin
        logic signed [CW-1:0] smag;
        smag        = {1'b0, r_dv[QD].sq};
        n_cs.valid  = r_dv[QD].valid;
        n_cs.k      = r_dv[QD].k;
        n_cs.vel    = r_dv[QD].vel;
        if (r_dv[QD].dxz) begin
            n_cs.c = '0;
            n_cs.s = CW'(1) <<< FRAC_BITS;
        end else begin
            n_cs.c = {1'b0, r_dv[QD].cq};
            n_cs.s = r_dv[QD].sneg ? -smag : smag;
        end
    end

    // Products of the forward rotation.
    always_comb begin
        n_p1.valid = r_cs.valid;
        n_p1.c     = r_cs.c;
        n_p1.s     = r_cs.s;
        n_p1.k     = r_cs.k;
        n_p1.p[0]  = mul_cv(r_cs.c, $signed(r_cs.vel[0]));
        n_p1.p[1]  = mul_cv(r_cs.s, $signed(r_cs.vel[1]));
        n_p1.p[2]  = mul_cv(r_cs.c, $signed(r_cs.vel[1]));
        n_p1.p[3]  = mul_cv(r_cs.s, $signed(r_cs.vel[0]));
        n_p1.p[4]  = mul_cv(r_cs.c, $signed(r_cs.vel[2]));
        n_p1.p[5]  = mul_cv(r_cs.s, $signed(r_cs.vel[3]));
        n_p1.p[6]  = mul_cv(r_cs.c, $signed(r_cs.vel[3]));
        n_p1.p[7]  = mul_cv(r_cs.s, $signed(r_cs.vel[2]));
    end

    // Forward rotation sums, floored back to the velocity scale.
    always_comb begin
        logic signed [PW1:0] t;
        n_p2.valid = r_p1.valid;
        n_p2.c     = r_p1.c;
        n_p2.s     = r_p1.s;
        n_p2.k     = r_p1.k;
        for (int i = 0; i < 4; i++) begin
            if (i % 2 == 0) begin
                t = {r_p1.p[2*i][PW1-1], r_p1.p[2*i]}
                  + {r_p1.p[2*i+1][PW1-1], r_p1.p[2*i+1]};
            end else begin
                t = {r_p1.p[2*i][PW1-1], r_p1.p[2*i]}
                  - {r_p1.p[2*i+1][PW1-1], r_p1.p[2*i+1]};
            end
            n_p2.r[i] = RW'(t >>> FRAC_BITS);
        end
    end

    // Difference of the axial velocities.
    always_comb begin
        n_p3.valid = r_p2.valid;
        n_p3.c     = r_p2.c;
        n_p3.s     = r_p2.s;
        n_p3.k     = r_p2.k;
        n_p3.r     = r_p2.r;
        n_p3.dr    = {r_p2.r[0][RW-1], r_p2.r[0]} - {r_p2.r[2][RW-1], r_p2.r[2]};
    end

    // Mass-ratio product k * (v1 - v2).
    always_comb begin
        logic signed [KPW-1:0] ke;
        logic signed [KPW-1:0] de;
        ke = {{(KPW-K_W){r_p3.k[K_W-1]}}, r_p3.k};
        de = {{(KPW-DW){r_p3.dr[DW-1]}}, r_p3.dr};
        n_p4.valid = r_p3.valid;
        n_p4.c     = r_p3.c;
        n_p4.s     = r_p3.s;
        n_p4.r     = r_p3.r;
        n_p4.kp    = ke * de;
    end

    // Axial velocities after the collision.
    always_comb begin
        logic signed [KPW-1:0] tk;
        logic signed [NW-1:0]  term;
        tk   = r_p4.kp >>> KBITS;
        term = tk[NW-1:0];
        n_p5.valid = r_p4.valid;
        n_p5.c     = r_p4.c;
        n_p5.s     = r_p4.s;
        n_p5.n1x   = {{(NW-RW){r_p4.r[2][RW-1]}}, r_p4.r[2]} + term;
        n_p5.n2x   = {{(NW-RW){r_p4.r[0][RW-1]}}, r_p4.r[0]} + term;
        n_p5.r1y   = r_p4.r[1];
        n_p5.r2y   = r_p4.r[3];
    end

    // Products of the reverse rotation.
    always_comb begin
        logic signed [NW-1:0] y1;
        logic signed [NW-1:0] y2;
        y1 = {{(NW-RW){r_p5.r1y[RW-1]}}, r_p5.r1y};
        y2 = {{(NW-RW){r_p5.r2y[RW-1]}}, r_p5.r2y};
        n_p6.valid = r_p5.valid;
        n_p6.p[0]  = mul_cn(r_p5.c, r_p5.n1x);
        n_p6.p[1]  = mul_cn(r_p5.s, y1);
        n_p6.p[2]  = mul_cn(r_p5.c, y1);
        n_p6.p[3]  = mul_cn(r_p5.s, r_p5.n1x);
        n_p6.p[4]  = mul_cn(r_p5.c, r_p5.n2x);
        n_p6.p[5]  = mul_cn(r_p5.s, y2);
        n_p6.p[6]  = mul_cn(r_p5.c, y2);
        n_p6.p[7]  = mul_cn(r_p5.s, r_p5.n2x);
    end

    // Reverse rotation sums, floor shift and saturation to 32 bits.
    always_comb begin
        logic signed [SW2-1:0]  t;
        logic signed [SW2-1:0]  sh;
        logic [SW2-Q_W:0]       hi;
        logic                   ovf;
        n_p7.valid = r_p6.valid;
        n_p7.sat   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (i % 2 == 0) begin
                t = {r_p6.p[2*i][PW2-1], r_p6.p[2*i]}
                  - {r_p6.p[2*i+1][PW2-1], r_p6.p[2*i+1]};
            end else begin
                t = {r_p6.p[2*i][PW2-1], r_p6.p[2*i]}
                  + {r_p6.p[2*i+1][PW2-1], r_p6.p[2*i+1]};
            end
            sh  = t >>> FRAC_BITS;
            hi  = sh[SW2-1:Q_W-1];
            ovf = !((&hi) || !(|hi));
            if (!ovf) begin
                n_p7.v[i] = sh[Q_W-1:0];
            end else if (sh[SW2-1]) begin
                n_p7.v[i] = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
                n_p7.v[i] = {1'b0, {(Q_W-1){1'b1}}};
            end
            n_p7.sat = n_p7.sat || ovf;
        end
    end

    // Pipeline registers outside the generated stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid    <= 1'b0;
            r_s1.valid    <= 1'b0;
            r_s2.valid    <= 1'b0;
            r_s3.valid    <= 1'b0;
            r_s4.valid    <= 1'b0;
            r_sq[0].valid <= 1'b0;
            r_cs.valid    <= 1'b0;
            r_p1.valid    <= 1'b0;
            r_p2.valid    <= 1'b0;
            r_p3.valid    <= 1'b0;
            r_p4.valid    <= 1'b0;
            r_p5.valid    <= 1'b0;
            r_p6.valid    <= 1'b0;
            r_p7.valid    <= 1'b0;
        end else if (en) begin
            r_s0    <= n_s0;
            r_s1    <= n_s1;
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_s4    <= n_s4;
            r_sq[0] <= n_sq[0];
            r_cs    <= n_cs;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_p4    <= n_p4;
            r_p5    <= n_p5;
            r_p6    <= n_p6;
            r_p7    <= n_p7;
        end
    end

    // Output register with a skid register behind it.
    assign out_ready = !r_out.valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (out_ready) begin
                r_out       <= r_skid;
                r_out.valid <= 1'b1;
                r_skid_full <= 1'b0;
            end
        end else if (out_ready) begin
            r_out <= r_p7;
        end else if (r_p7.valid) begin
            r_skid_full <= 1'b1;
        end
    end

    // The skid register only captures payload; its flag lives above.
    always_ff @(posedge i_clk) begin
        if (!r_skid_full && !out_ready && r_p7.valid) begin
            r_skid <= r_p7;
        end
    end

    assign o_valid       = r_out.valid;
    assign o_new_vel_a_x = r_out.v[0];
    assign o_new_vel_a_y = r_out.v[1];
    assign o_new_vel_b_x = r_out.v[2];
    assign o_new_vel_b_y = r_out.v[3];
    assign o_saturated   = r_out.sat;

endmodule

// ===== hdl/ec2d_checker.sv =====
// Port-level checks for the elastic collision core, with its bind.
// Depends on ec2d_pkg and on elastic_collision_2d_core.
module ec2d_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input ec2d_pkg::t_q  o_new_vel_a_x,
    input logic          o_saturated
);
    import ec2d_pkg::*;

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_vel_a_x) && $stable(o_saturated))
        else $error("stalled result changed");

    // The input side is only held back after the output was stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stalled without an output stall");

    // A held-back input always means a result is waiting.
    a_stall_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result on the output");

    // Once the output is taken, the input side is released next cycle.
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input stall not released after the output drained");

endmodule

bind elastic_collision_2d_core ec2d_checker u_ec2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_new_vel_a_x (o_new_vel_a_x),
    .o_saturated   (o_saturated)
);

// ===== verif/elastic_collision_2d_core_tb.sv =====
// Self-checking testbench for the 2-D elastic collision core.
// Depends on ec2d_pkg and elastic_collision_2d_core; predicts each result in a scoreboard class.
module elastic_collision_2d_core_tb;
    import ec2d_pkg::*;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby, ma, mb;
    } t_pair;

    typedef struct packed {
        logic [31:0] nax, nay, nbx, nby;
        logic        sat;
    } t_bounce;

    // Floor shift right of a wide signed value.
    function automatic logic signed [127:0] floor_shift(logic signed [127:0] x, int n);
        return x >>> n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp32(logic signed [127:0] x, ref logic flag);
        if (x > 128'sd2147483647) begin
            flag = 1'b1;
            return 32'h7fffffff;
        end
        if (x < -128'sd2147483648) begin
            flag = 1'b1;
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    // Computes the post-collision velocities of one pair.
    function automatic t_bounce collide(t_pair p);
        logic signed [127:0] dx, dy, c, s, v1x, v1y, v2x, v2y, r1x, r1y, r2x, r2y;
        logic signed [127:0] k, msum, term, n1x, n2x;
        logic [63:0] ax, ay, m, rr;
        t_bounce res;
        logic flag;
        flag = 1'b0;
        dx = $signed(p.pax) - $signed(p.pbx);
        dy = $signed(p.pay) - $signed(p.pby);
        v1x = $signed(p.vax);
        v1y = $signed(p.vay);
        v2x = $signed(p.vbx);
        v2y = $signed(p.vby);
        if (dx == 0) begin
            c = '0;
            s = 128'sd1 <<< FRAC;
        end else begin
            ax = 64'(dx < 0 ? -dx : dx);
            ay = 64'(dy < 0 ? -dy : dy);
            m = ax > ay ? ax : ay;
            if (m >= (64'd1 << 31)) begin
                ax >>= 1;
                ay >>= 1;
            end else begin
                while (m < (64'd1 << 30)) begin
                    ax <<= 1;
                    ay <<= 1;
                    m <<= 1;
                end
            end
            rr = int_sqrt(ax * ax + ay * ay);
            c = $signed({64'd0, (ax << FRAC) / rr});
            s = $signed({64'd0, (ay << FRAC) / rr});
            if (dy != 0 && ((dx < 0) != (dy < 0))) s = -s;
        end
        r1x = floor_shift(c * v1x + s * v1y, FRAC);
        r1y = floor_shift(c * v1y - s * v1x, FRAC);
        r2x = floor_shift(c * v2x + s * v2y, FRAC);
        r2y = floor_shift(c * v2y - s * v2x, FRAC);
        msum = $signed({96'd0, p.ma} + {96'd0, p.mb});
        // Division truncates toward zero, as the ratio requires.
        k = (msum == 0) ? 128'sd0
            : ((($signed({96'd0, p.ma}) - $signed({96'd0, p.mb})) <<< KBITS) / msum);
        term = floor_shift(k * (r1x - r2x), KBITS);
        n1x = r2x + term;
        n2x = r1x + term;
        res.nax = clamp32(floor_shift(c * n1x - s * r1y, FRAC), flag);
        res.nay = clamp32(floor_shift(c * r1y + s * n1x, FRAC), flag);
        res.nbx = clamp32(floor_shift(c * n2x - s * r2y, FRAC), flag);
        res.nby = clamp32(floor_shift(c * r2y + s * n2x, FRAC), flag);
        res.sat = flag;
        return res;
    endfunction

    class bounce_scoreboard;
        t_bounce pending[$];
        int errors = 0;
        int checked = 0;
        int saturations = 0;

        function void note_pair(t_pair p);
            pending.push_back(collide(p));
        endfunction

        function void check_bounce(t_bounce got);
            t_bounce want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.sat) saturations++;
            if (got.nax !== want.nax)
                $display("%0t: new_vel_a_x exp %h got %h", $realtime, want.nax, got.nax);
            if (got.nay !== want.nay)
                $display("%0t: new_vel_a_y exp %h got %h", $realtime, want.nay, got.nay);
            if (got.nbx !== want.nbx)
                $display("%0t: new_vel_b_x exp %h got %h", $realtime, want.nbx, got.nbx);
            if (got.nby !== want.nby)
                $display("%0t: new_vel_b_y exp %h got %h", $realtime, want.nby, got.nby);
            if (got.sat !== want.sat)
                $display("%0t: saturated exp %b got %b", $realtime, want.sat, got.sat);
            if (got !== want) errors++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_pair pair_in = '0;
    logic o_stall, o_valid, o_saturated;
    t_q o_nax, o_nay, o_nbx, o_nby;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    int quiet = 0;
    bounce_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    elastic_collision_2d_core #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_a_x(pair_in.pax), .i_pos_a_y(pair_in.pay),
        .i_pos_b_x(pair_in.pbx), .i_pos_b_y(pair_in.pby),
        .i_vel_a_x(pair_in.vax), .i_vel_a_y(pair_in.vay),
        .i_vel_b_x(pair_in.vbx), .i_vel_b_y(pair_in.vby),
        .i_mass_a(pair_in.ma), .i_mass_b(pair_in.mb),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_new_vel_a_x(o_nax), .o_new_vel_a_y(o_nay),
        .o_new_vel_b_x(o_nbx), .o_new_vel_b_y(o_nby), .o_saturated(o_saturated)
    );

    // Accepted items on both channels feed the scoreboard; the watchdog watches for progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_pair(pair_in);
            if (o_valid && !i_stall) sb.check_bounce({o_nax, o_nay, o_nbx, o_nby, o_saturated});
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Timeout after %0d quiet cycles", quiet);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Receiver stall, random or held off for a long stretch.
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom_range(3) - 2;
            3: return $signed($urandom_range(2097152)) - 1048576;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(4))
            0: return 32'd1;
            1: return 32'hffffffff;
            2: return $urandom_range(32'h40000, 1);
            default: return $urandom | 32'd1;
        endcase
    endfunction

    // Offers one item, holding it until the core accepts it.
    task automatic send_pair(t_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        pair_in <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        t_pair p;
        repeat (n) begin
            p = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                 rand_word(), rand_word(), rand_word(), rand_mass(), rand_mass()};
            // Equal x positions now and then.
            if ($urandom_range(9) == 0) p.pbx = p.pax;
            if ($urandom_range(19) == 0) p.mb = p.ma;
            send_pair(p);
        end
    endtask

    initial begin
        t_pair p;
        int wait_cycles;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs: equal x (also with equal y), extremes, mass ratios.
        p = '0;
        p.ma = 32'h10000; p.mb = 32'h10000; p.vax = 32'h10000; p.vbx = 32'hffff0000;
        send_pair(p);
        p.pax = 32'h20000; send_pair(p);
        p.pay = 32'h30000; send_pair(p);
        p.pax = 32'h0; p.pay = 32'h50000; send_pair(p);
        p.pax = 32'h80000000; p.pbx = 32'h7fffffff; p.pay = 32'h7fffffff;
        p.pby = 32'h80000000; send_pair(p);
        p.vax = 32'h7fffffff; p.vay = 32'h80000000; p.vbx = 32'h80000000;
        p.vby = 32'h7fffffff; send_pair(p);
        p.ma = 32'hffffffff; p.mb = 32'd1; send_pair(p);
        p.ma = 32'd1; p.mb = 32'hffffffff; send_pair(p);
        p.pax = 32'h1; p.pbx = 32'h0; p.pay = 32'hffffffff; p.pby = 32'h0; send_pair(p);
        p.pax = 32'hffffffff; p.pay = 32'h1; send_pair(p);
        p.pax = 32'h00010000; p.pay = 32'h00010000; p.pbx = 0; p.pby = 0; send_pair(p);
        p.ma = 32'h30000; p.mb = 32'h10000; send_pair(p);

        send_idle_pct = 36; recv_idle_pct = 58;
        send_random(400);
        send_idle_pct = 58; recv_idle_pct = 36;
        send_random(400);

        // Long receiver hold-off while items keep coming, so the core backs up.
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random(150);
        join
        send_random(300);
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (FRAC + 60) @(posedge i_clk);

        $display("Checked %0d collision results, %0d with saturation.",
                 sb.checked, sb.saturations);
        $display("Stimulus covered equal x positions, extreme values and masses, and backpressure.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
